// ===== design/utf8sd_pkg.sv =====
package utf8sd_pkg;

   // Longest accepted sequence; longer lead bytes are treated as invalid.
   localparam int unsigned MAX_SEQ_BYTES = 6;

   localparam int unsigned CP_W     = 31;
   localparam int unsigned COUNT_W  = 16;
   localparam int unsigned CSR_IDX_W = 1;
   localparam int unsigned CSR_DATA_W = 16;

   // CSR indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT_ENABLE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHAR_LIMIT   = 1'd1;

   // Result status codes
   localparam logic [1:0] ST_CHAR  = 2'd0;
   localparam logic [1:0] ST_ERROR = 2'd1;
   localparam logic [1:0] ST_END   = 2'd2;
   localparam logic [1:0] ST_TRUNC = 2'd3;

   typedef struct packed {
      logic                limit_enable;
      logic [COUNT_W-1:0]  char_limit;
   } cfg_type;

   typedef struct packed {
      logic                valid;
      logic [CP_W-1:0]     code_point;
      logic [1:0]          status;
      logic [2:0]          seq_bytes;
      logic [COUNT_W-1:0]  char_total;
   } result_type;

   // Sequence length from the lead byte, 0 for an invalid lead.
   function automatic logic [2:0] lead_length(input logic [7:0] b);
      logic [2:0] len;
      if (b < 8'h80)      len = 3'd1;
      else if (b < 8'hC2) len = 3'd0;
      else if (b < 8'hE0) len = 3'd2;
      else if (b < 8'hF0) len = 3'd3;
      else if (b < 8'hF8) len = 3'd4;
      else if (b < 8'hFC) len = 3'd5;
      else if (b < 8'hFE) len = 3'd6;
      else                len = 3'd0;
      return len;
   endfunction

   // Bits of which the second byte needs at least one (0: no check).
   function automatic logic [7:0] second_required(input logic [7:0] b);
      logic [7:0] mask;
      case (b[4:0])
         5'h00:   mask = 8'h20;
         5'h10:   mask = 8'h30;
         5'h18:   mask = 8'h38;
         5'h1C:   mask = 8'h3C;
         5'h1E:   mask = 8'h00;
         5'h1F:   mask = 8'h00;
         default: mask = 8'h80;
      endcase
      return mask;
   endfunction

endpackage

// ===== design/utf8sd_core.sv =====
module utf8sd_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic [7:0]             byte_in,
   input  utf8sd_pkg::cfg_type    cfg,
   output utf8sd_pkg::result_type result
);

   typedef enum logic [1:0] {
      DROP_NONE  = 2'd0,
      DROP_ERROR = 2'd1,
      DROP_LIMIT = 2'd2
   } drop_type;

   logic [2:0]                       bytes_left_ff, bytes_left_in;
   logic [2:0]                       seq_len_ff, seq_len_in;
   logic [utf8sd_pkg::CP_W-1:0]      accum_ff, accum_in;
   logic [7:0]                       second_mask_ff, second_mask_in;
   logic                             at_second_ff, at_second_in;
   logic [utf8sd_pkg::COUNT_W-1:0]   chars_seen_ff, chars_seen_in;
   drop_type                         drop_ff, drop_in;

   logic [2:0]                       len;
   logic                             bad;
   logic [utf8sd_pkg::COUNT_W-1:0]   chars_inc;
   logic [utf8sd_pkg::CP_W-1:0]      accum_shift;

   assign len         = utf8sd_pkg::lead_length(byte_in);
   assign chars_inc   = (chars_seen_ff != {utf8sd_pkg::COUNT_W{1'b1}}) ?
                        chars_seen_ff + 1'b1 : chars_seen_ff;
   assign accum_shift = {accum_ff[utf8sd_pkg::CP_W-7:0], byte_in[5:0]};
   assign bad = (byte_in[7:6] != 2'b10) ||
                (at_second_ff && (second_mask_ff != 8'h00) &&
                 ((byte_in & second_mask_ff) == 8'h00));

   always_comb begin
      bytes_left_in  = bytes_left_ff;
      seq_len_in     = seq_len_ff;
      accum_in       = accum_ff;
      second_mask_in = second_mask_ff;
      at_second_in   = at_second_ff;
      chars_seen_in  = chars_seen_ff;
      drop_in        = drop_ff;
      result         = '0;

      if (drop_ff != DROP_NONE) begin
         if (byte_in == 8'h00) begin
            if (drop_ff == DROP_LIMIT) begin
               result.valid      = 1'b1;
               result.status     = utf8sd_pkg::ST_TRUNC;
               result.char_total = chars_seen_ff;
            end
            bytes_left_in  = '0;
            seq_len_in     = '0;
            accum_in       = '0;
            second_mask_in = '0;
            at_second_in   = 1'b0;
            chars_seen_in  = '0;
            drop_in        = DROP_NONE;
         end
      end else if (bytes_left_ff == 3'd0) begin
         if (byte_in == 8'h00) begin
            result.valid      = 1'b1;
            result.status     = utf8sd_pkg::ST_END;
            result.char_total = chars_seen_ff;
            bytes_left_in  = '0;
            seq_len_in     = '0;
            accum_in       = '0;
            second_mask_in = '0;
            at_second_in   = 1'b0;
            chars_seen_in  = '0;
         end else if (cfg.limit_enable && (chars_seen_ff >= cfg.char_limit)) begin
            drop_in = DROP_LIMIT;
         end else if ((len == 3'd0) || (len > 3'(utf8sd_pkg::MAX_SEQ_BYTES))) begin
            result.valid   = 1'b1;
            result.status  = utf8sd_pkg::ST_ERROR;
            bytes_left_in  = '0;
            seq_len_in     = '0;
            accum_in       = '0;
            second_mask_in = '0;
            at_second_in   = 1'b0;
            drop_in        = DROP_ERROR;
         end else if (len == 3'd1) begin
            result.valid      = 1'b1;
            result.status     = utf8sd_pkg::ST_CHAR;
            result.code_point = utf8sd_pkg::CP_W'(byte_in[6:0]);
            result.seq_bytes  = 3'd1;
            chars_seen_in     = chars_inc;
         end else begin
            // lead of a multi-byte sequence: keep the payload bits under the marker
            accum_in       = utf8sd_pkg::CP_W'(byte_in & (8'h7F >> len));
            seq_len_in     = len;
            bytes_left_in  = len - 3'd1;
            second_mask_in = (len >= 3'd3) ? utf8sd_pkg::second_required(byte_in) : 8'h00;
            at_second_in   = 1'b1;
         end
      end else if (bad) begin
         result.valid   = 1'b1;
         result.status  = utf8sd_pkg::ST_ERROR;
         bytes_left_in  = '0;
         seq_len_in     = '0;
         accum_in       = '0;
         second_mask_in = '0;
         at_second_in   = 1'b0;
         if (byte_in == 8'h00) begin
            chars_seen_in = '0;
         end else begin
            drop_in = DROP_ERROR;
         end
      end else if (bytes_left_ff == 3'd1) begin
         result.valid      = 1'b1;
         result.status     = utf8sd_pkg::ST_CHAR;
         result.code_point = accum_shift;
         result.seq_bytes  = seq_len_ff;
         bytes_left_in     = '0;
         seq_len_in        = '0;
         accum_in          = '0;
         second_mask_in    = '0;
         at_second_in      = 1'b0;
         chars_seen_in     = chars_inc;
      end else begin
         accum_in      = accum_shift;
         at_second_in  = 1'b0;
         bytes_left_in = bytes_left_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_left_ff  <= '0;
         seq_len_ff     <= '0;
         accum_ff       <= '0;
         second_mask_ff <= '0;
         at_second_ff   <= 1'b0;
         chars_seen_ff  <= '0;
         drop_ff        <= DROP_NONE;
      end else if (step) begin
         bytes_left_ff  <= bytes_left_in;
         seq_len_ff     <= seq_len_in;
         accum_ff       <= accum_in;
         second_mask_ff <= second_mask_in;
         at_second_ff   <= at_second_in;
         chars_seen_ff  <= chars_seen_in;
         drop_ff        <= drop_in;
      end
   end

endmodule

// ===== design/utf8_stream_decoder.sv =====
// UTF-8 stream decoder: NUL-terminated UTF-8 bytes in, 31-bit code points out.
// Input channel (req_): one byte per transfer on req_valid / req_stall.
// Result channel (rsp_): at most one result per byte: a character with its
// sequence length, an invalid-sequence flag, or an end-of-string record that
// carries the character count (status 3 when the character limit cut it short).
// CSR port: csr_write_enable with csr_index / csr_write_data, no read-back;
// write only while the decoder is idle.
// A transferred byte is held in the input register, passes the decode step
// and its result is captured in the result register that drives rsp_.
// Throughput is one byte per clock while rsp_stall holds no pending result;
// the rate is set by the single decode step between the input register and
// the result register. Bytes that yield no result (leading and continuation
// bytes of a multi-byte sequence, dropped bytes) still pass the decode step.
// Stall: when rsp_stall holds a pending result, the decode step waits and
// the input register fills; req_stall then rises in the same cycle.
// Reset (synchronous): clears CSRs, the decode state and the valid flags of both registers.
module utf8_stream_decoder (
   input  logic                                 clock,
   input  logic                                 reset,
   // input channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [7:0]                           req_in_byte,
   // result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [utf8sd_pkg::CP_W-1:0]          rsp_code_point,
   output logic [1:0]                           rsp_status,
   output logic [2:0]                           rsp_seq_bytes,
   output logic [utf8sd_pkg::COUNT_W-1:0]       rsp_char_total,
   // configuration
   input  logic                                 csr_write_enable,
   input  logic [utf8sd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [utf8sd_pkg::CSR_DATA_W-1:0]    csr_write_data
);

   // CSRs
   utf8sd_pkg::cfg_type      cfg_ff;

   // input register
   logic                     in_valid_ff, in_valid_in;
   logic [7:0]               in_byte_ff;

   // result register
   logic                     rsp_valid_ff, rsp_valid_in;
   utf8sd_pkg::result_type   rsp_ff;

   logic                     out_free;
   logic                     step;
   utf8sd_pkg::result_type   result;

   // Decode step runs when a byte is held and the result register can take
   // a new value (empty, or draining in this cycle).
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   assign in_valid_in  = req_stall ? in_valid_ff : req_valid;
   assign rsp_valid_in = step ? result.valid : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.limit_enable <= 1'b0;
         cfg_ff.char_limit   <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            utf8sd_pkg::CSR_LIMIT_ENABLE: cfg_ff.limit_enable <= csr_write_data[0];
            utf8sd_pkg::CSR_CHAR_LIMIT:   cfg_ff.char_limit   <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_in_byte;
      end
      if (step && result.valid) begin
         rsp_ff <= result;
      end
   end

   utf8sd_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .byte_in (in_byte_ff),
      .cfg     (cfg_ff),
      .result  (result)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_code_point = rsp_ff.code_point;
   assign rsp_status     = rsp_ff.status;
   assign rsp_seq_bytes  = rsp_ff.seq_bytes;
   assign rsp_char_total = rsp_ff.char_total;

endmodule
